// ----- hdl/wall_follow_pid_steering_assert.svh -----
// Assertion macros for the wall-follow steering block.
// Included by the top level; expands to nothing when SYNTH is defined.
`ifndef WALL_FOLLOW_PID_STEERING_ASSERT_SVH
`define WALL_FOLLOW_PID_STEERING_ASSERT_SVH

`ifndef SYNTH
`define WFPS_ASSERT(lbl, ck, rs, a, c, m) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error(m);
`define WFPS_ASSERT_NEXT(lbl, ck, rs, a, c, m) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error(m);
`else
`define WFPS_ASSERT(lbl, ck, rs, a, c, m)
`define WFPS_ASSERT_NEXT(lbl, ck, rs, a, c, m)
`endif

`endif

// ----- hdl/wfps_pkg.sv -----
// Shared types, codes and constants for the wall-follow steering block.
// No dependencies.
package wfps_pkg;

  // register indexes on the config port
  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd2;
  localparam logic [1:0] REG_TARGET     = 2'd3;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd2048;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd205;
  localparam logic [15:0] DERIV_GAIN_RST = 16'd819;
  localparam logic [11:0] TARGET_RST     = 12'd1800;

  // what an item turns into after the state stage
  localparam logic [1:0] CLS_PID  = 2'd0;
  localparam logic [1:0] CLS_SPIN = 2'd1;
  localparam logic [1:0] CLS_NONE = 2'd2;

  localparam logic [2:0] MAN_STRAIGHT   = 3'd0;
  localparam logic [2:0] MAN_SOFT_LEFT  = 3'd1;
  localparam logic [2:0] MAN_HARD_LEFT  = 3'd2;
  localparam logic [2:0] MAN_SOFT_RIGHT = 3'd3;
  localparam logic [2:0] MAN_HARD_RIGHT = 3'd4;
  localparam logic [2:0] MAN_SPIN       = 3'd5;
  localparam logic [2:0] MAN_NONE       = 3'd6;

  localparam logic [11:0] FAR_FRONT  = 12'd3000;
  localparam logic [11:0] FAR_RIGHT  = 12'd1000;
  localparam logic [11:0] NEAR_FRONT = 12'd850;
  localparam int SUM_LIMIT = 20000;
  localparam int SUM_RESET = 10000;

  // band edges in accumulator units (output * 4096 * 20)
  localparam logic signed [39:0] BAND_LOW  = 40'sd1638400;
  localparam logic signed [39:0] BAND_MID  = 40'sd40960000;
  localparam logic signed [39:0] BAND_HIGH = 40'sd81920000;

  typedef struct packed {
    logic [1:0]          cls;
    logic signed [17:0]  err20;    // 20 * error
    logic signed [22:0]  diff400;  // 400 * (error - last error)
    logic signed [15:0]  sum;      // clamped error sum
  } track_t;

  typedef struct packed {
    logic [1:0]          cls;
    logic signed [33:0]  p_term;
    logic signed [38:0]  d_term;
    logic signed [31:0]  i_term;
  } prod_t;

  typedef struct packed {
    logic [7:0] left_power;
    logic [7:0] right_power;
    logic       left_dir;
  } drive_t;

  function automatic drive_t drive_of(input logic [2:0] man);
    drive_t d;
    d = '0;
    case (man)
      MAN_STRAIGHT:   d = '{8'd250, 8'd250, 1'b0};
      MAN_SOFT_LEFT:  d = '{8'd225, 8'd125, 1'b0};
      MAN_HARD_LEFT:  d = '{8'd250, 8'd50,  1'b0};
      MAN_SOFT_RIGHT: d = '{8'd125, 8'd225, 1'b0};
      MAN_HARD_RIGHT: d = '{8'd50,  8'd250, 1'b0};
      MAN_SPIN:       d = '{8'd250, 8'd250, 1'b1};
      default:        d = '0;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/wfps_sample_if.sv -----
// Input channel of the wall-follow steering block: two distance samples and abort.
// No dependencies.
interface wfps_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] right_sample;
  logic [11:0] front_sample;
  logic        abort_turn;

  modport source (output valid, right_sample, front_sample, abort_turn, input ready);
  modport sink   (input valid, right_sample, front_sample, abort_turn, output ready);
endinterface

// ----- hdl/wfps_command_if.sv -----
// Output channel of the wall-follow steering block: motor powers, pins, maneuver.
// No dependencies.
interface wfps_command_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_power;
  logic [7:0] right_power;
  logic       left_dir_pin;
  logic       right_dir_pin;
  logic [2:0] maneuver;

  modport source (output valid, left_power, right_power, left_dir_pin, right_dir_pin,
                  maneuver, input ready);
  modport sink   (input valid, left_power, right_power, left_dir_pin, right_dir_pin,
                  maneuver, output ready);
endinterface

// ----- hdl/wfps_track.sv -----
// Input register plus loop state: error, clamped error sum, turn mode.
// Depends on wfps_pkg and wfps_sample_if.
module wfps_track (
  input  logic                 clk,
  input  logic                 rst,
  wfps_sample_if.sink          sample,
  input  logic [11:0]          target_distance,
  output logic                 trk_valid,
  input  logic                 trk_ready,
  output wfps_pkg::track_t     trk_data
);
  import wfps_pkg::*;

  logic        in_valid;
  logic        in_ready;
  logic [11:0] right;
  logic [11:0] front;
  logic        abort_now;
  logic        advance;

  logic               turning;
  logic signed [12:0] last_error;
  logic signed [15:0] err_sum;

  logic               turning_next;
  logic signed [12:0] last_error_next;
  logic signed [15:0] err_sum_next;
  track_t             trk_next;

  logic signed [12:0] err;
  logic signed [16:0] sum_raw;
  logic signed [15:0] sum_clamped;
  logic signed [13:0] diff;
  logic signed [17:0] err_ext;
  logic signed [22:0] diff_ext;

  assign in_ready     = !in_valid || trk_ready;
  assign sample.ready = in_ready;
  assign advance      = in_valid && trk_ready;

  always_comb begin
    err      = $signed({1'b0, target_distance}) - $signed({1'b0, right});
    sum_raw  = $signed({err_sum[15], err_sum}) + $signed({{4{err[12]}}, err});
    if (sum_raw < -SUM_LIMIT) begin
      sum_clamped = -16'sd10000;
    end else if (sum_raw > SUM_LIMIT) begin
      sum_clamped = 16'sd10000;
    end else begin
      sum_clamped = sum_raw[15:0];
    end
    diff     = $signed({err[12], err}) - $signed({last_error[12], last_error});
    err_ext  = {{5{err[12]}}, err};
    diff_ext = {{9{diff[13]}}, diff};

    turning_next    = turning;
    last_error_next = last_error;
    err_sum_next    = err_sum;
    trk_next.cls     = CLS_PID;
    trk_next.err20   = (err_ext <<< 4) + (err_ext <<< 2);
    trk_next.diff400 = (diff_ext <<< 8) + (diff_ext <<< 7) + (diff_ext <<< 4);
    trk_next.sum     = sum_clamped;

    if (turning) begin
      if (abort_now) begin
        turning_next = 1'b0;
        err_sum_next = '0;
        trk_next.cls = CLS_NONE;
      end else begin
        trk_next.cls = CLS_SPIN;
        if (front < NEAR_FRONT) begin
          turning_next = 1'b0;
          err_sum_next = '0;
        end
      end
    end else begin
      last_error_next = err;
      err_sum_next    = sum_clamped;
      // far wall ahead and open on the right: start a U-turn, or clear the sum on abort
      if (front > FAR_FRONT && right > FAR_RIGHT) begin
        trk_next.cls = CLS_NONE;
        if (abort_now) begin
          err_sum_next = '0;
        end else begin
          turning_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      trk_valid  <= 1'b0;
      turning    <= 1'b0;
      last_error <= '0;
      err_sum    <= '0;
    end else begin
      if (in_ready) begin
        in_valid <= sample.valid;
      end
      if (trk_ready) begin
        trk_valid <= in_valid;
      end
      if (advance) begin
        turning    <= turning_next;
        last_error <= last_error_next;
        err_sum    <= err_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && in_ready) begin
      right     <= sample.right_sample;
      front     <= sample.front_sample;
      abort_now <= sample.abort_turn;
    end
    if (advance) begin
      trk_data <= trk_next;
    end
  end

endmodule

// ----- hdl/wfps_mult.sv -----
// Gain products stage: three signed-by-unsigned multiplies, registered.
// Depends on wfps_pkg.
module wfps_mult (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       prop_gain,
  input  logic [15:0]       integ_gain,
  input  logic [15:0]       deriv_gain,
  input  logic              trk_valid,
  output logic              trk_ready,
  input  wfps_pkg::track_t  trk_data,
  output logic              prd_valid,
  input  logic              prd_ready,
  output wfps_pkg::prod_t   prd_data
);
  import wfps_pkg::*;

  logic signed [34:0] p_full;
  logic signed [39:0] d_full;
  logic signed [32:0] i_full;

  assign trk_ready = !prd_valid || prd_ready;

  assign p_full = $signed({1'b0, prop_gain})  * trk_data.err20;
  assign d_full = $signed({1'b0, deriv_gain}) * trk_data.diff400;
  assign i_full = $signed({1'b0, integ_gain}) * trk_data.sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      prd_valid <= 1'b0;
    end else if (trk_ready) begin
      prd_valid <= trk_valid;
    end
  end

  // magnitudes stay inside the narrower fields; the top bits are sign copies
  always_ff @(posedge clk) begin
    if (trk_valid && trk_ready) begin
      prd_data.cls    <= trk_data.cls;
      prd_data.p_term <= p_full[33:0];
      prd_data.d_term <= d_full[38:0];
      prd_data.i_term <= i_full[31:0];
    end
  end

endmodule

// ----- hdl/wfps_band.sv -----
// Sum of gain products, band compare and result register.
// Depends on wfps_pkg and wfps_command_if.
module wfps_band (
  input  logic             clk,
  input  logic             rst,
  input  logic             prd_valid,
  output logic             prd_ready,
  input  wfps_pkg::prod_t  prd_data,
  wfps_command_if.source   command
);
  import wfps_pkg::*;

  logic signed [39:0] acc;
  logic [2:0]         man;
  drive_t             drv;
  logic               out_valid;

  assign prd_ready     = !out_valid || command.ready;
  assign command.valid = out_valid;

  assign acc = $signed({{6{prd_data.p_term[33]}}, prd_data.p_term})
             + $signed({prd_data.d_term[38], prd_data.d_term})
             + $signed({{8{prd_data.i_term[31]}}, prd_data.i_term});

  always_comb begin
    case (prd_data.cls)
      CLS_PID: begin
        if (acc > BAND_LOW && acc < BAND_MID) begin
          man = MAN_SOFT_LEFT;
        end else if (acc > BAND_MID) begin
          man = MAN_HARD_LEFT;
        end else if (acc < -BAND_LOW && acc > -BAND_HIGH) begin
          man = MAN_SOFT_RIGHT;
        end else if (acc < -BAND_MID) begin
          man = MAN_HARD_RIGHT;
        end else begin
          man = MAN_STRAIGHT;
        end
      end
      CLS_SPIN: man = MAN_SPIN;
      default:  man = MAN_NONE;
    endcase
    drv = drive_of(man);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prd_ready) begin
      out_valid <= prd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prd_valid && prd_ready) begin
      command.left_power    <= drv.left_power;
      command.right_power   <= drv.right_power;
      command.left_dir_pin  <= drv.left_dir;
      command.right_dir_pin <= 1'b0;
      command.maneuver      <= man;
    end
  end

endmodule

// ----- hdl/wall_follow_pid_steering.sv -----
// Top level of the wall-follow PID steering block: config registers and stage wiring.
// Depends on wfps_pkg, the two channel interfaces, wfps_track, wfps_mult, wfps_band.
`include "wall_follow_pid_steering_assert.svh"

// Four register stages: input register, error and loop-state update, gain
// products, band decode into the result register. A sample passes through them
// in that order, and one sample is taken per cycle as long as results are
// drained; a stage holds only while the product and result stages, where they
// lie after it, are full and the result side is stalled.
// The error sum, last error and turn flag update as an item leaves the input
// register, so the next sample already sees them, with no gap. Write the
// gain and target registers only while no item is in flight.
module wall_follow_pid_steering (
  input  logic            clk,
  input  logic            rst,
  wfps_sample_if.sink     sample,
  wfps_command_if.source  command,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import wfps_pkg::*;

  logic [15:0] prop_gain;
  logic [15:0] integ_gain;
  logic [15:0] deriv_gain;
  logic [11:0] target_distance;

  logic   s1_valid;
  logic   s1_ready;
  track_t s1_data;
  logic   s2_valid;
  logic   s2_ready;
  prod_t  s2_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= PROP_GAIN_RST;
      integ_gain      <= INTEG_GAIN_RST;
      deriv_gain      <= DERIV_GAIN_RST;
      target_distance <= TARGET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain       <= cfg_data;
        REG_INTEG_GAIN: integ_gain      <= cfg_data;
        REG_DERIV_GAIN: deriv_gain      <= cfg_data;
        REG_TARGET:     target_distance <= cfg_data[11:0];
      endcase
    end
  end

  wfps_track u_track (
    .clk             (clk),
    .rst             (rst),
    .sample          (sample),
    .target_distance (target_distance),
    .trk_valid       (s1_valid),
    .trk_ready       (s1_ready),
    .trk_data        (s1_data)
  );

  wfps_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .prop_gain  (prop_gain),
    .integ_gain (integ_gain),
    .deriv_gain (deriv_gain),
    .trk_valid  (s1_valid),
    .trk_ready  (s1_ready),
    .trk_data   (s1_data),
    .prd_valid  (s2_valid),
    .prd_ready  (s2_ready),
    .prd_data   (s2_data)
  );

  wfps_band u_band (
    .clk       (clk),
    .rst       (rst),
    .prd_valid (s2_valid),
    .prd_ready (s2_ready),
    .prd_data  (s2_data),
    .command   (command)
  );

  `WFPS_ASSERT(a_sum_in_range, clk, rst, s1_valid, s1_data.sum <= SUM_LIMIT && s1_data.sum >= -SUM_LIMIT, "error sum escaped its clamp")
  `WFPS_ASSERT_NEXT(a_prod_hold, clk, rst, s2_valid && !s2_ready, s2_valid && $stable(s2_data), "product stage lost a stalled item")
  `WFPS_ASSERT(a_dir_only_spin, clk, rst, command.valid && command.left_dir_pin, command.maneuver == MAN_SPIN, "left direction pin outside spin")
  `WFPS_ASSERT(a_none_is_off, clk, rst, command.valid && command.maneuver == MAN_NONE, command.left_power == 8'd0 && command.right_power == 8'd0 && !command.left_dir_pin, "no-command result drives motors")

endmodule

// ----- verif/wall_follow_pid_steering_tb.sv -----
// Self-checking testbench for wall_follow_pid_steering: random and directed sensor items,
// an in-order PID/band predictor, and a per-field check of every steering command.
// Depends on wfps_pkg, wfps_sample_if, wfps_command_if and the block itself.
module wall_follow_pid_steering_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER  = 100;   // items sent before the long output stall
  localparam int HOLD_CYCLES = 120;
  localparam int CALM_FROM   = 400;   // no random idling on either side in this window
  localparam int CALM_TO     = 520;
  localparam int MAX_PRINTS  = 40;

  localparam int FRONT_OPEN   = 3000;
  localparam int RIGHT_OPEN   = 1000;
  localparam int FRONT_CLOSE  = 850;
  localparam int SUM_CAP      = 20000;
  localparam int SUM_FALLBACK = 10000;
  localparam longint ACC_UNIT = 81920;  // 4096 * 20

  typedef struct packed {
    logic [7:0] left_power;
    logic [7:0] right_power;
    logic       left_dir;
    logic       right_dir;
    logic [2:0] maneuver;
  } steer_cmd_t;

  typedef struct {
    logic [11:0] right_s;
    logic [11:0] front_s;
    logic        abort_s;
    bit          drain_first;
  } sensor_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  wfps_sample_if  smp();
  wfps_command_if cmd();

  wall_follow_pid_steering uut (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .command   (cmd),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and loop state
  logic [15:0]        gain_p    = 16'd2048;
  logic [15:0]        gain_i    = 16'd205;
  logic [15:0]        gain_d    = 16'd819;
  logic [11:0]        set_point = 12'd1800;
  logic signed [12:0] prev_err  = '0;
  logic signed [15:0] err_sum   = '0;
  logic               in_uturn  = 1'b0;

  sensor_item_t sensor_backlog[$];
  steer_cmd_t   cmd_due[$];

  int  n_sent = 0;
  int  n_seen = 0;
  int  mismatches = 0;
  int  cycle_cnt = 0;
  int  hold_left;
  bit  hold_done;
  bit  wait_drain_next = 1'b0;
  logic calm;

  assign calm = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic steer_cmd_t steer_for(input logic [11:0] right, input logic [11:0] front,
                                           input logic abort_now);
    int         err;
    int         sum;
    int         diff;
    longint     acc;
    logic [2:0] man;
    steer_cmd_t c;
    man = MAN_NONE;
    if (in_uturn) begin
      if (abort_now) begin
        in_uturn = 1'b0;
        err_sum  = '0;
      end else begin
        man = MAN_SPIN;
        if (int'(front) < FRONT_CLOSE) begin
          in_uturn = 1'b0;
          err_sum  = '0;
        end
      end
    end else begin
      err = int'(set_point) - int'(right);
      sum = int'(err_sum) + err;
      if (sum < -SUM_CAP)
        sum = -SUM_FALLBACK;
      else if (sum > SUM_CAP)
        sum = SUM_FALLBACK;
      diff = err - int'(prev_err);
      acc = 20 * longint'(gain_p) * longint'(err)
          + 400 * longint'(gain_d) * longint'(diff)
          + longint'(gain_i) * longint'(sum);
      err_sum  = 16'(sum);
      prev_err = 13'(err);
      if (int'(front) > FRONT_OPEN && int'(right) > RIGHT_OPEN) begin
        if (abort_now)
          err_sum = '0;
        else
          in_uturn = 1'b1;
      end else if (acc > 20 * ACC_UNIT && acc < 500 * ACC_UNIT) begin
        man = MAN_SOFT_LEFT;
      end else if (acc > 500 * ACC_UNIT) begin
        man = MAN_HARD_LEFT;
      end else if (acc < -20 * ACC_UNIT && acc > -1000 * ACC_UNIT) begin
        man = MAN_SOFT_RIGHT;
      end else if (acc < -500 * ACC_UNIT) begin
        man = MAN_HARD_RIGHT;
      end else begin
        man = MAN_STRAIGHT;
      end
    end
    c = '0;
    c.maneuver = man;
    case (man)
      MAN_STRAIGHT: begin
        c.left_power = 8'd250; c.right_power = 8'd250;
      end
      MAN_SOFT_LEFT: begin
        c.left_power = 8'd225; c.right_power = 8'd125;
      end
      MAN_HARD_LEFT: begin
        c.left_power = 8'd250; c.right_power = 8'd50;
      end
      MAN_SOFT_RIGHT: begin
        c.left_power = 8'd125; c.right_power = 8'd225;
      end
      MAN_HARD_RIGHT: begin
        c.left_power = 8'd50; c.right_power = 8'd250;
      end
      MAN_SPIN: begin
        c.left_power = 8'd250; c.right_power = 8'd250; c.left_dir = 1'b1;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch cycle %0d result %0d: %s got %0d want %0d",
               cycle_cnt, n_seen, what, got, want);
  endtask

  function automatic void push_sensor(input logic [11:0] r, input logic [11:0] f,
                                      input logic a);
    sensor_item_t it;
    it.right_s = r;
    it.front_s = f;
    it.abort_s = a;
    it.drain_first = wait_drain_next;
    wait_drain_next = 1'b0;
    sensor_backlog.push_back(it);
  endfunction

  // Mostly well-formed traffic: wall-follow runs around the target and U-turn
  // sequences (start, spins, exit by near wall or abort), with some raw noise.
  task automatic add_random_items(input int n, input bit drain_head);
    int added;
    int spread;
    int pos;
    int spins;
    logic [11:0] front;
    added = 0;
    wait_drain_next = drain_head;
    while (added < n) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          case ($urandom_range(3))
            0: spread = 20;
            1: spread = 200;
            2: spread = 1000;
            default: spread = 4095;
          endcase
          repeat ($urandom_range(12, 3)) begin
            pos = int'($urandom_range(2 * spread)) - spread + int'(set_point);
            if (pos < 0) pos = 0;
            if (pos > 4095) pos = 4095;
            front = ($urandom_range(9) == 0) ? 12'($urandom_range(4095, 3001))
                                             : 12'($urandom_range(3000));
            push_sensor(12'(pos), front, $urandom_range(9) == 0);
            added++;
          end
        end
        12, 13, 14, 15, 16: begin
          push_sensor(12'($urandom_range(4095, 1001)), 12'($urandom_range(4095, 3001)),
                      $urandom_range(5) == 0);
          added++;
          spins = $urandom_range(5);
          repeat (spins) begin
            push_sensor(12'($urandom()), 12'($urandom_range(4095, 850)), 1'b0);
            added++;
          end
          case ($urandom_range(4))
            0, 1: begin
              push_sensor(12'($urandom()), 12'($urandom_range(849)), 1'b0);
              added++;
            end
            2, 3: begin
              push_sensor(12'($urandom()), 12'($urandom()), 1'b1);
              added++;
            end
            default: ;  // spin carries on into whatever follows
          endcase
        end
        default: begin
          push_sensor(12'($urandom()), 12'($urandom()), 1'($urandom()));
          added++;
        end
      endcase
    end
  endtask

  task automatic set_gains(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                           input logic [11:0] t);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PROP_GAIN;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= REG_INTEG_GAIN;
    cfg_data  <= i;
    @(posedge clk);
    cfg_index <= REG_DERIV_GAIN;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= REG_TARGET;
    cfg_data  <= {4'd0, t};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (sensor_backlog.size() != 0 || smp.valid || cmd_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  // predictor view of the register file
  always @(posedge clk) begin
    if (!rst && cfg_wr_en) begin
      case (cfg_index)
        REG_PROP_GAIN:  gain_p <= cfg_data;
        REG_INTEG_GAIN: gain_i <= cfg_data;
        REG_DERIV_GAIN: gain_d <= cfg_data;
        REG_TARGET:     set_point <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // sample driver
  always @(posedge clk) begin : drive
    sensor_item_t nxt;
    logic take;
    logic go;
    logic drained;
    if (rst) begin
      smp.valid <= 1'b0;
    end else begin
      take = smp.valid && smp.ready;
      if (take) begin
        cmd_due.push_back(steer_for(smp.right_sample, smp.front_sample, smp.abort_turn));
        n_sent <= n_sent + 1;
      end
      if (!smp.valid || take) begin
        go = 1'b0;
        if (sensor_backlog.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          drained = !take && (n_sent == n_seen + ((cmd.valid && cmd.ready) ? 1 : 0));
          go = !sensor_backlog[0].drain_first || drained;
        end
        if (go) begin
          nxt = sensor_backlog.pop_front();
          smp.valid        <= 1'b1;
          smp.right_sample <= nxt.right_s;
          smp.front_sample <= nxt.front_s;
          smp.abort_turn   <= nxt.abort_s;
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // long output stall once, so the pipeline fills and backs up the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_sent >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // command monitor
  always @(posedge clk) begin : watch
    steer_cmd_t want;
    if (rst) begin
      cmd.ready <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        n_seen <= n_seen + 1;
        if (cmd_due.size() == 0) begin
          report_mismatch("command with no item pending, maneuver", cmd.maneuver, -1);
        end else begin
          want = cmd_due.pop_front();
          if (cmd.left_power !== want.left_power)
            report_mismatch("left_power", cmd.left_power, want.left_power);
          if (cmd.right_power !== want.right_power)
            report_mismatch("right_power", cmd.right_power, want.right_power);
          if (cmd.left_dir_pin !== want.left_dir)
            report_mismatch("left_dir_pin", cmd.left_dir_pin, want.left_dir);
          if (cmd.right_dir_pin !== want.right_dir)
            report_mismatch("right_dir_pin", cmd.right_dir_pin, want.right_dir);
          if (cmd.maneuver !== want.maneuver)
            report_mismatch("maneuver", cmd.maneuver, want.maneuver);
        end
      end
      cmd.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_PROP_GAIN;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.right_sample = '0;
    smp.front_sample = '0;
    smp.abort_turn = 1'b0;
    cmd.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset gains and target
    push_sensor(12'd1800, 12'd1000, 1'b0);  // on target
    push_sensor(12'd1750, 12'd1000, 1'b0);
    push_sensor(12'd0,    12'd0,    1'b0);  // both sensors at minimum
    push_sensor(12'd1800, 12'd2000, 1'b0);
    push_sensor(12'd1900, 12'd2000, 1'b0);
    push_sensor(12'd4095, 12'd3000, 1'b0);  // front just not far
    push_sensor(12'd1000, 12'd4095, 1'b0);  // right just not far
    push_sensor(12'd1001, 12'd3001, 1'b0);  // U-turn starts
    push_sensor(12'd0,    12'd4095, 1'b0);  // spin
    push_sensor(12'd4095, 12'd850,  1'b0);  // spin, front not yet near
    push_sensor(12'd2000, 12'd849,  1'b0);  // spin, ends on near front
    push_sensor(12'd1800, 12'd1200, 1'b1);  // abort outside a turn
    push_sensor(12'd4095, 12'd4095, 1'b0);  // U-turn starts, both at maximum
    push_sensor(12'd0,    12'd0,    1'b1);  // abort while spinning
    push_sensor(12'd2500, 12'd3500, 1'b1);  // U-turn start with abort
    push_sensor(12'd1810, 12'd1500, 1'b0);
    push_sensor(12'd1795, 12'd1500, 1'b0);
    push_sensor(12'd1800, 12'd1500, 1'b0);
    push_sensor(12'd3000, 12'd100,  1'b1);
    push_sensor(12'd1100, 12'd3001, 1'b0);
    push_sensor(12'd1800, 12'd0,    1'b0);  // spin ends, front at zero
    push_sensor(12'd2048, 12'd2048, 1'b0);
    wait_idle();

    set_gains(16'd2048, 16'd205, 16'd819, 12'd1800);
    add_random_items(120, 1'b0);
    wait_idle();

    // all maximum; target high drives the sum into the positive clamp
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095);
    add_random_items(60, 1'b0);
    add_random_items(60, 1'b1);
    wait_idle();

    // all zero; errors never positive, sum hits the negative clamp
    set_gains(16'd0, 16'd0, 16'd0, 12'd0);
    add_random_items(120, 1'b0);
    wait_idle();

    set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 12'($urandom()));
    add_random_items(120, 1'b0);
    wait_idle();

    set_gains(16'd0, 16'hFFFF, 16'd0, 12'd2048);
    add_random_items(100, 1'b0);
    wait_idle();

    set_gains(16'($urandom_range(8191)), 16'($urandom_range(1023)),
              16'($urandom_range(4095)), 12'($urandom_range(2800, 800)));
    add_random_items(120, 1'b0);
    wait_idle();

    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
